[rtl/clook_pkg.sv]
// ----------------------------------------------------------------------------
// clook_pkg
// Shared types and defaults for the C-LOOK disk request scheduler.
// ----------------------------------------------------------------------------
package clook_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_SECTOR_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_POP,
    ST_HEAD_RD,
    ST_HEAD_LD,
    ST_DONE
  } state_t;

  localparam logic ACT_ARRIVE   = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

endpackage

[rtl/clook_disk_scheduler.sv]
// ----------------------------------------------------------------------------
// clook_disk_scheduler
// C-LOOK request scheduler: sorted sweep queue plus a wait queue for requests
// below the head, both held in one small RAM and driven by a sequencer.
//
// Usage: raise start with action and request_sector while busy is low; the
// transfer happens on that edge and busy stays high until the result.
// action 0 is an arrival, action 1 a dispatch. The result shows for one cycle
// with done high; the receiver cannot stall it.
// Steps from the accepting edge to the done cycle:
//   arrival  : a sorted insert that steps past queued entries (at most
//              QUEUE_DEPTH - 1), each step a RAM read then a compare/write;
//              a full queue goes straight to done.
//   dispatch : pop, then read the new head unless no request is left.
// The insert loop runs one RAM read and one compare/write per step; that
// single port pair sets the rate. One item at a time; the next start is
// taken in the cycle after done.
// Reset clears both queues and the head; the RAM needs no clearing pass as
// only occupied entries are ever read.
// ----------------------------------------------------------------------------
module clook_disk_scheduler #(
  parameter int QUEUE_DEPTH = clook_pkg::DEF_QUEUE_DEPTH,
  parameter int SECTOR_BITS = clook_pkg::DEF_SECTOR_BITS,
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action,
  input  logic [SECTOR_BITS-1:0] request_sector,
  output logic                   done,
  output logic                   accepted,
  output logic                   served_valid,
  output logic [SECTOR_BITS-1:0] served_sector,
  output logic [SECTOR_BITS-1:0] head_sector,
  output logic [CW-1:0]          sweep_count,
  output logic [CW-1:0]          wait_count
);

  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  clook_pkg::state_t state, state_next;

  logic [SECTOR_BITS-1:0] mem [2**(IW+1)];
  logic [SECTOR_BITS-1:0] rdata;
  logic [IW:0]            raddr, waddr;
  logic                   wen;
  logic [SECTOR_BITS-1:0] wdata;

  logic                   sel;
  logic [IW-1:0]          sweep_base, wait_base;
  logic [CW-1:0]          sweep_n, wait_n;
  logic [SECTOR_BITS-1:0] head;
  logic [SECTOR_BITS-1:0] sector;
  logic                   ins_wait;
  logic [IW-1:0]          pos;
  logic                   acc, sv;
  logic [SECTOR_BITS-1:0] ss;

  logic                   to_wait;
  logic [CW-1:0]          tgt_n;
  logic                   tgt_bank;
  logic [IW-1:0]          tgt_base;
  logic                   shift_up;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] b,
                                             input logic [IW-1:0] i);
    logic [IW:0] sum;
    sum = {1'b0, b} + {1'b0, i};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IW-1:0];
  endfunction

  assign to_wait  = (request_sector < head);
  assign tgt_n    = to_wait ? wait_n : sweep_n;
  assign tgt_bank = ins_wait ? ~sel : sel;
  assign tgt_base = ins_wait ? wait_base : sweep_base;
  assign shift_up = (rdata > sector);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      clook_pkg::ST_IDLE: begin
        if (start) begin
          if (action == clook_pkg::ACT_DISPATCH) begin
            state_next = clook_pkg::ST_POP;
          end else if (tgt_n == DEPTH_C) begin
            state_next = clook_pkg::ST_DONE;
          end else begin
            state_next = clook_pkg::ST_INS_RD;
          end
        end
      end
      clook_pkg::ST_INS_RD: begin
        state_next = (pos == '0) ? clook_pkg::ST_DONE : clook_pkg::ST_INS_CMP;
      end
      clook_pkg::ST_INS_CMP: begin
        state_next = shift_up ? clook_pkg::ST_INS_RD : clook_pkg::ST_DONE;
      end
      clook_pkg::ST_POP: begin
        if (sweep_n != '0 || wait_n != '0) begin
          state_next = clook_pkg::ST_HEAD_RD;
        end else begin
          state_next = clook_pkg::ST_DONE;
        end
      end
      clook_pkg::ST_HEAD_RD: state_next = clook_pkg::ST_HEAD_LD;
      clook_pkg::ST_HEAD_LD: state_next = clook_pkg::ST_DONE;
      clook_pkg::ST_DONE:    state_next = clook_pkg::ST_IDLE;
      default:               state_next = clook_pkg::ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    raddr = {sel, sweep_base};
    wen   = 1'b0;
    waddr = {tgt_bank, wrap_add(tgt_base, pos)};
    wdata = sector;
    case (state)
      clook_pkg::ST_INS_RD: begin
        raddr = {tgt_bank, wrap_add(tgt_base, pos - IW'(1))};
        wen   = (pos == '0);
      end
      clook_pkg::ST_INS_CMP: begin
        wen   = 1'b1;
        wdata = shift_up ? rdata : sector;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= clook_pkg::ST_IDLE;
      sel        <= 1'b0;
      sweep_base <= '0;
      wait_base  <= '0;
      sweep_n    <= '0;
      wait_n     <= '0;
      head       <= '0;
      acc        <= 1'b0;
      sv         <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        clook_pkg::ST_IDLE: begin
          if (start) begin
            sector   <= request_sector;
            ins_wait <= to_wait;
            pos      <= tgt_n[IW-1:0];
            if (action == clook_pkg::ACT_DISPATCH) begin
              acc <= 1'b0;
              if (sweep_n != '0) begin
                sv         <= 1'b1;
                ss         <= head;
                sweep_base <= wrap_add(sweep_base, IW'(1));
                sweep_n    <= sweep_n - CW'(1);
              end else begin
                sv <= 1'b0;
                ss <= '0;
              end
            end else begin
              acc <= (tgt_n != DEPTH_C);
              sv  <= 1'b0;
              ss  <= '0;
            end
          end
        end
        clook_pkg::ST_INS_RD, clook_pkg::ST_INS_CMP: begin
          if (state == clook_pkg::ST_INS_CMP && shift_up) begin
            pos <= pos - IW'(1);
          end else if (state == clook_pkg::ST_INS_CMP || pos == '0) begin
            if (ins_wait) begin
              wait_n <= wait_n + CW'(1);
            end else begin
              sweep_n <= sweep_n + CW'(1);
              if (sweep_n == '0) begin
                head <= sector;
              end
            end
          end
        end
        clook_pkg::ST_POP: begin
          if (sweep_n == '0) begin
            sel        <= ~sel;
            sweep_base <= wait_base;
            wait_base  <= sweep_base;
            sweep_n    <= wait_n;
            wait_n     <= '0;
            if (wait_n == '0) begin
              head <= '0;
            end
          end
        end
        clook_pkg::ST_HEAD_LD: begin
          head <= rdata;
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  assign busy          = (state != clook_pkg::ST_IDLE);
  assign done          = (state == clook_pkg::ST_DONE);
  assign accepted      = acc;
  assign served_valid  = sv;
  assign served_sector = ss;
  assign head_sector   = head;
  assign sweep_count   = sweep_n;
  assign wait_count    = wait_n;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (sweep_n <= DEPTH_C) && (wait_n <= DEPTH_C))
    else $error("queue count beyond depth");

  a_empty_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == clook_pkg::ST_IDLE && sweep_n == '0) |-> (wait_n == '0 && head == '0))
    else $error("wait queue left behind an empty sweep queue");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer not taken up");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(accepted && served_valid))
    else $error("result both stored and served");

endmodule

[bench/clook_disk_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clook_disk_scheduler_tb
// Self-checking bench for the C-LOOK scheduler. A scoreboard class keeps its
// own sweep and wait queues and head position. For every request transfer it
// works out the expected result, and each done strobe is checked field by
// field against the oldest pending result. A short directed run covers empty
// and full queues, ties and the queue hand-over. Random phases then fill,
// drain and mix traffic, with random gaps on the request side.
// ----------------------------------------------------------------------------
module clook_disk_scheduler_tb;

  localparam int DEPTH       = clook_pkg::DEF_QUEUE_DEPTH;
  localparam int SBITS       = clook_pkg::DEF_SECTOR_BITS;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int N_RANDOM    = 1300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

  typedef logic [SBITS-1:0] sector_t;

  typedef struct packed {
    logic          accepted;
    logic          served_valid;
    sector_t       served_sector;
    sector_t       head_sector;
    logic [CW-1:0] sweep_count;
    logic [CW-1:0] wait_count;
  } sched_result_t;

  class clook_scoreboard;
    sector_t       sweep_q[$];
    sector_t       wait_q[$];
    sector_t       head = '0;
    sched_result_t pending[$];
    int            errors = 0;

    // first slot after every entry <= s, so ties keep arrival order
    function int slot_after(sector_t q[$], sector_t s);
      int pos;
      pos = q.size();
      while (pos > 0 && q[pos-1] > s) pos--;
      return pos;
    endfunction

    function void note_transfer(logic act, sector_t sec);
      sched_result_t r;
      logic          was_empty;
      r = '0;
      if (act == clook_pkg::ACT_ARRIVE) begin
        if (sec < head) begin
          if (wait_q.size() < DEPTH) begin
            wait_q.insert(slot_after(wait_q, sec), sec);
            r.accepted = 1'b1;
          end
        end else begin
          was_empty = (sweep_q.size() == 0);
          if (sweep_q.size() < DEPTH) begin
            sweep_q.insert(slot_after(sweep_q, sec), sec);
            r.accepted = 1'b1;
            if (was_empty) head = sec;
          end
        end
      end else begin
        if (sweep_q.size() > 0) begin
          r.served_valid  = 1'b1;
          r.served_sector = sweep_q.pop_front();
          head = (sweep_q.size() > 0) ? sweep_q[0] : '0;
        end
        if (sweep_q.size() == 0) begin
          sweep_q = wait_q;
          wait_q.delete();
          head = (sweep_q.size() > 0) ? sweep_q[0] : '0;
        end
      end
      r.head_sector = head;
      r.sweep_count = CW'(sweep_q.size());
      r.wait_count  = CW'(wait_q.size());
      pending.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (pending.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      compare_field("accepted", exp.accepted, got.accepted);
      compare_field("served_valid", exp.served_valid, got.served_valid);
      compare_field("served_sector", exp.served_sector, got.served_sector);
      compare_field("head_sector", exp.head_sector, got.head_sector);
      compare_field("sweep_count", exp.sweep_count, got.sweep_count);
      compare_field("wait_count", exp.wait_count, got.wait_count);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          action = clook_pkg::ACT_ARRIVE;
  sector_t       request_sector = '0;
  logic          busy;
  logic          done;
  logic          accepted;
  logic          served_valid;
  sector_t       served_sector;
  sector_t       head_sector;
  logic [CW-1:0] sweep_count;
  logic [CW-1:0] wait_count;

  clook_scoreboard sb;
  int unsigned     cycle_count = 0;

  always #2 clk = ~clk;

  clook_disk_scheduler uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .request_sector (request_sector),
    .done           (done),
    .accepted       (accepted),
    .served_valid   (served_valid),
    .served_sector  (served_sector),
    .head_sector    (head_sector),
    .sweep_count    (sweep_count),
    .wait_count     (wait_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{accepted, served_valid, served_sector, head_sector,
                        sweep_count, wait_count});
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a clock edge; leaves start high so back-to-back requests
  // never see start lowered and raised in one step.
  task automatic send_request(logic act, sector_t sec, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action         <= act;
    request_sector <= sec;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_transfer(act, sec);
  endtask

  function automatic sector_t pick_sector(int mode);
    int r;
    case (mode)
      0: return sector_t'($urandom_range(0, 2**SBITS - 1));
      1: return sector_t'($urandom_range(0, 15));
      2: begin
        r = $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return sector_t'($urandom);
      end
      default: return sb.head + sector_t'($urandom_range(0, 6)) - sector_t'(3);
    endcase
  endfunction

  initial begin
    int    arrive_pct;
    int    phase_left;
    int    sector_mode;
    bit    no_idle;
    logic  act;

    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dispatch, ties at head, below-head, extremes, hand-over
    send_request(clook_pkg::ACT_DISPATCH, '0, 0);
    send_request(clook_pkg::ACT_ARRIVE, sector_t'(100), 1);
    send_request(clook_pkg::ACT_ARRIVE, sector_t'(100), 0);
    send_request(clook_pkg::ACT_ARRIVE, sector_t'(50), 2);
    send_request(clook_pkg::ACT_ARRIVE, '1, 0);
    send_request(clook_pkg::ACT_ARRIVE, '0, 0);
    repeat (3) send_request(clook_pkg::ACT_DISPATCH, '1, pick_gap());
    // fill the sweep queue past full
    repeat (DEPTH - 1) send_request(clook_pkg::ACT_ARRIVE, '1, pick_gap());
    send_request(clook_pkg::ACT_DISPATCH, '0, 0);

    phase_left = 0;
    arrive_pct = 50;
    sector_mode = 0;
    no_idle = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: arrive_pct = 85;
          1: arrive_pct = 20;
          default: arrive_pct = 50;
        endcase
        sector_mode = $urandom_range(0, 3);
        no_idle = ($urandom_range(0, 4) == 0);
      end
      phase_left--;
      act = ($urandom_range(0, 99) < arrive_pct) ? clook_pkg::ACT_ARRIVE
                                                 : clook_pkg::ACT_DISPATCH;
      send_request(act, pick_sector(sector_mode), no_idle ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
